### design/byte_addressed_data_memory_defines.svh
`ifndef BYTE_ADDRESSED_DATA_MEMORY_DEFINES_SVH
`define BYTE_ADDRESSED_DATA_MEMORY_DEFINES_SVH

// Antecedent holds, consequent holds in the same cycle.
`define BAM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent holds, consequent holds in the next cycle.
`define BAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### design/bam_pkg.sv
`default_nettype none

package bam_pkg;

	localparam int MEM_BYTES_DEF = 65536;

	localparam int CFG_W       = 17;
	localparam int ADDR_W      = 32;
	localparam int DATA_W      = 64;
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 64;

	localparam logic [CFG_W-1:0] MEM_SIZE_RST = 17'd65536;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [1:0] SZ_BYTE  = 2'd0;
	localparam logic [1:0] SZ_HALF  = 2'd1;
	localparam logic [1:0] SZ_WORD  = 2'd2;
	localparam logic [1:0] SZ_DWORD = 2'd3;

	typedef logic [7:0] byte_t;

endpackage

`default_nettype wire

### design/byte_addressed_data_memory.sv
// Channel   Dir  tdata (low bit first)                          tuser
// s_*       in   address, access_size, sign_extend,             command
//                big_endian, write_data, zero fill
// m_*       out  read_data                                      error
// cfg_*     in   mem_size (written when cfg_we is high)         -
//
// Each beat passes in turn through capture, memory access and result assembly.
// The store is eight byte-wide lane memories, one read or write port each.
// After reset a clearing pass writes zero to every row, during which
// s_tready stays low.
// A new beat is taken while a finished result waits in the output register;
// the access then holds in the assembly step until m_tready frees the register.
`default_nettype none
`include "byte_addressed_data_memory_defines.svh"

module byte_addressed_data_memory
	import bam_pkg::*;
#(
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// address[31:0], access_size[33:32], sign_extend[34], big_endian[35],
	// write_data[99:36], zero[103:100]
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// command[0]
	input  wire logic                   s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// read_data[63:0]
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	// error[0]
	output logic                        m_tuser,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_W-1:0]       cfg_wdata
);

	localparam int ROWS = (MEM_BYTES + 7) / 8;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W + 1)'(MEM_BYTES);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;
	localparam logic [1:0] ST_RESP  = 2'd3;

	logic [1:0]        state_q;
	logic [RW-1:0]     clr_row_q;
	logic [CFG_W-1:0]  mem_size_q;

	logic              cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [1:0]        size_q;
	logic              sext_q;
	logic              big_q;
	logic [DATA_W-1:0] wdata_q;
	logic              err_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_err_q;

	logic              s_accept;
	logic              out_free;
	logic [2:0]        nm1;
	logic [2:0]        a0;
	logic [ADDR_W:0]   last_byte;
	logic [ADDR_W:0]   size_eff;
	logic              err_now;
	logic [RW-1:0]     row0;
	logic [RW-1:0]     row1;

	logic              lane_we [8];
	logic              lane_re [8];
	logic [RW-1:0]     lane_addr [8];
	byte_t             lane_wd [8];
	byte_t             lane_rd [8];

	logic [DATA_W-1:0] load_raw;
	logic [DATA_W-1:0] load_ext;

	assign s_accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;

	assign nm1  = {size_q == SZ_DWORD, size_q[1], size_q != SZ_BYTE};
	assign a0   = addr_q[2:0];
	assign row0 = addr_q[RW+2:3];
	assign row1 = row0 + 1'b1;

	assign last_byte = {1'b0, addr_q} + (ADDR_W + 1)'(nm1);
	assign size_eff  = ((ADDR_W + 1)'(mem_size_q) > MEM_LIMIT) ? MEM_LIMIT
		: (ADDR_W + 1)'(mem_size_q);
	assign err_now   = (last_byte >= size_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q <= MEM_SIZE_RST;
		end else if (cfg_we) begin
			mem_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_row_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && state_q != ST_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_row_q <= clr_row_q + 1'b1;
					if (clr_row_q == RW'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_q   <= s_tuser;
			addr_q  <= s_tdata[31:0];
			size_q  <= s_tdata[33:32];
			sext_q  <= s_tdata[34];
			big_q   <= s_tdata[35];
			wdata_q <= s_tdata[99:36];
		end
		if (state_q == ST_EXEC) begin
			err_q <= err_now;
		end
		if (state_q == ST_RESP && out_free) begin
			out_data_q <= load_ext;
			out_err_q  <= err_q;
		end
	end

	// Lane l holds every byte whose address is l modulo eight. Lanes below the
	// start offset take the following row. The one-cycle write lands before any
	// later beat can read, since beats do not overlap.
	always_comb begin
		logic [2:0] li;
		logic [2:0] pos;
		logic       in_acc;
		for (int l = 0; l < 8; l++) begin
			li     = 3'(l) - a0;
			in_acc = (li <= nm1);
			pos    = big_q ? (nm1 - li) : li;
			if (state_q == ST_CLEAR) begin
				lane_we[l]   = 1'b1;
				lane_re[l]   = 1'b0;
				lane_addr[l] = clr_row_q;
				lane_wd[l]   = '0;
			end else begin
				lane_we[l]   = (state_q == ST_EXEC) && (cmd_q == CMD_WRITE)
					&& !err_now && in_acc;
				lane_re[l]   = (state_q == ST_EXEC) && (cmd_q == CMD_READ)
					&& !err_now && in_acc;
				lane_addr[l] = (3'(l) < a0) ? row1 : row0;
				lane_wd[l]   = wdata_q[8*pos +: 8];
			end
		end
	end

	for (genvar g = 0; g < 8; g++) begin : g_lane
		bam_lane_ram #(
			.DEPTH (ROWS)
		) u_lane (
			.clk   (clk),
			.we    (lane_we[g]),
			.re    (lane_re[g]),
			.addr  (lane_addr[g]),
			.wdata (lane_wd[g]),
			.rdata (lane_rd[g])
		);
	end

	always_comb begin
		logic [2:0] lane;
		logic [2:0] pos;
		load_raw = '0;
		for (int i = 0; i < 8; i++) begin
			lane = a0 + 3'(i);
			pos  = big_q ? (nm1 - 3'(i)) : 3'(i);
			if (3'(i) <= nm1) begin
				load_raw[8*pos +: 8] = lane_rd[lane];
			end
		end
	end

	always_comb begin
		logic [DATA_W-1:0] ext;
		unique case (size_q)
			SZ_BYTE:  ext = {{56{sext_q && load_raw[7]}}, load_raw[7:0]};
			SZ_HALF:  ext = {{48{sext_q && load_raw[15]}}, load_raw[15:0]};
			SZ_WORD:  ext = {{32{sext_q && load_raw[31]}}, load_raw[31:0]};
			SZ_DWORD: ext = load_raw;
			default:  ext = load_raw;
		endcase
		load_ext = (err_q || cmd_q == CMD_WRITE) ? '0 : ext;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_err_q;

	`BAM_ASSERT_SAME(a_no_accept_in_clear, clk, arst_n,
		state_q == ST_CLEAR, !s_tready)
	`BAM_ASSERT_NEXT(a_accept_to_exec, clk, arst_n,
		s_accept, state_q == ST_EXEC)
	`BAM_ASSERT_SAME(a_write_only_exec_or_clear, clk, arst_n,
		lane_we[0] || lane_we[7],
		state_q == ST_CLEAR || (state_q == ST_EXEC && cmd_q == CMD_WRITE))
	`BAM_ASSERT_SAME(a_error_reads_zero, clk, arst_n,
		m_tvalid && m_tuser, m_tdata == '0)

endmodule

`default_nettype wire

### design/bam_lane_ram.sv
`default_nettype none

module bam_lane_ram
	import bam_pkg::*;
#(
	parameter int DEPTH = MEM_BYTES_DEF / 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic          re,
	input  wire logic [AW-1:0] addr,
	input  wire byte_t         wdata,
	output byte_t              rdata
);

	byte_t mem [DEPTH];
	byte_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### sim/mem_access_checker.sv
module mem_access_checker
	import bam_pkg::*;
#(
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	// address[31:0], access_size[33:32], sign_extend[34], big_endian[35],
	// write_data[99:36], zero[103:100]
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// command[0]
	input  wire logic                   s_tuser,
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	// read_data[63:0]
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,
	// error[0]
	input  wire logic                   m_tuser,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_W-1:0]       cfg_wdata,
	output int                          fail_count,
	output int                          outstanding
);

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              error;
	} mem_resp_t;

	byte_t            mem_image [0:MEM_BYTES-1];
	logic [CFG_W-1:0] size_reg;
	mem_resp_t        pending_responses [$];
	int               mismatches;

	initial begin
		for (int i = 0; i < MEM_BYTES; i++) begin
			mem_image[i] = 8'h00;
		end
		size_reg = MEM_SIZE_RST;
		mismatches = 0;
	end

	function automatic mem_resp_t predict_access(input logic cmd,
			input logic [ADDR_W-1:0] addr, input logic [1:0] size_code,
			input logic sext, input logic big, input logic [DATA_W-1:0] wdata);
		mem_resp_t   resp;
		int          nbytes;
		int          pos;
		int          bits;
		logic [33:0] last_byte;
		logic [33:0] limit;
		nbytes = 1 << size_code;
		last_byte = {2'b00, addr} + 34'(nbytes) - 34'd1;
		limit = (size_reg > MEM_BYTES) ? 34'(MEM_BYTES) : 34'(size_reg);
		resp.read_data = '0;
		resp.error = 1'b0;
		if (last_byte >= limit) begin
			resp.error = 1'b1;
			return resp;
		end
		for (int i = 0; i < nbytes; i++) begin
			pos = big ? (nbytes - 1 - i) : i;
			if (cmd == CMD_WRITE) begin
				mem_image[int'(addr) + i] = wdata[8*pos +: 8];
			end else begin
				resp.read_data[8*pos +: 8] = mem_image[int'(addr) + i];
			end
		end
		if (cmd == CMD_READ && sext && nbytes < 8) begin
			bits = 8 * nbytes;
			if (resp.read_data[bits-1]) begin
				resp.read_data = resp.read_data | ~((64'd1 << bits) - 64'd1);
			end
		end
		return resp;
	endfunction

	always @(posedge clk) begin
		mem_resp_t exp_resp;
		if (arst_n) begin
			if (cfg_we) begin
				size_reg = cfg_wdata;
			end
			if (s_tvalid && s_tready) begin
				pending_responses.push_back(predict_access(s_tuser, s_tdata[31:0],
					s_tdata[33:32], s_tdata[34], s_tdata[35], s_tdata[99:36]));
			end
			if (m_tvalid && m_tready) begin
				if (pending_responses.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected beat: read_data %h error %b", m_tdata, m_tuser);
					end
				end else begin
					exp_resp = pending_responses.pop_front();
					if (m_tdata !== exp_resp.read_data || m_tuser !== exp_resp.error) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display({"mismatch: expected read_data %h error %b, ",
								"got read_data %h error %b"},
								exp_resp.read_data, exp_resp.error, m_tdata, m_tuser);
						end
					end
				end
			end
		end
		fail_count <= mismatches;
		outstanding <= pending_responses.size();
	end

endmodule

### sim/tb_top.sv
module tb_top;
	import bam_pkg::*;

	localparam int IDLE_LIMIT = 30000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   cfg_we = 1'b0;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	int                     fail_count;
	int                     outstanding;

	int cur_size = MEM_BYTES_DEF;
	int beat_count = 0;
	bit burst_mode = 1'b0;
	int ready_left = 0;
	int ready_roll;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	byte_addressed_data_memory dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	mem_access_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		if (ready_left > 0) begin
			ready_left <= ready_left - 1;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 8) begin
				m_tready <= 1'b0;
				ready_left <= $urandom_range(20, 80);
			end else if (ready_roll < 40) begin
				m_tready <= 1'b0;
				ready_left <= $urandom_range(1, 4);
			end else if (ready_roll < 50) begin
				m_tready <= 1'b1;
				ready_left <= $urandom_range(100, 300);
			end else begin
				m_tready <= 1'b1;
				ready_left <= $urandom_range(1, 8);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic issue(input logic cmd, input logic [ADDR_W-1:0] addr,
			input logic [1:0] size_code, input logic sext, input logic big,
			input logic [DATA_W-1:0] wdata);
		int gap;
		int roll;
		beat_count++;
		if (beat_count % 64 == 0) begin
			burst_mode = ($urandom_range(0, 99) < 30);
		end
		roll = $urandom_range(0, 99);
		if (burst_mode || roll < 50) begin
			gap = 0;
		end else if (roll < 92) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, wdata, big, sext, size_code, addr};
		s_tuser <= cmd;
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	task automatic issue_random();
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] limit;
		int                roll;
		limit = (cur_size > MEM_BYTES_DEF) ? MEM_BYTES_DEF : cur_size;
		roll = $urandom_range(0, 99);
		if (roll < 50) begin
			addr = $urandom_range(0, 63);
		end else if (roll < 70) begin
			addr = limit - $urandom_range(0, 12);
		end else if (roll < 85) begin
			addr = $urandom_range(0, 65535);
		end else if (roll < 93) begin
			addr = $urandom;
		end else begin
			addr = 32'hFFFF_FFF0 + $urandom_range(0, 15);
		end
		issue(1'($urandom_range(0, 1)), addr, 2'($urandom_range(0, 3)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), {$urandom, $urandom});
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] size_val, input int beats);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= size_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_size = int'(size_val);
		repeat (beats) issue_random();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_phase(MEM_SIZE_RST, 0);

		issue(CMD_WRITE, 32'd0, SZ_DWORD, 1'b0, 1'b0, 64'h8877_6655_4433_2211);
		issue(CMD_READ, 32'd0, SZ_DWORD, 1'b0, 1'b0, 64'h0);
		issue(CMD_READ, 32'd0, SZ_DWORD, 1'b0, 1'b1, 64'h0);
		issue(CMD_READ, 32'd7, SZ_BYTE, 1'b1, 1'b0, 64'h0);
		issue(CMD_READ, 32'd7, SZ_BYTE, 1'b0, 1'b0, 64'h0);
		issue(CMD_READ, 32'd6, SZ_HALF, 1'b1, 1'b1, 64'h0);
		issue(CMD_READ, 32'd4, SZ_WORD, 1'b1, 1'b0, 64'h0);
		issue(CMD_WRITE, 32'd3, SZ_WORD, 1'b1, 1'b1, 64'hFFFF_FFFF_DEAD_BEEF);
		issue(CMD_READ, 32'd3, SZ_WORD, 1'b0, 1'b0, 64'h0);
		issue(CMD_READ, 32'd4, SZ_HALF, 1'b1, 1'b0, 64'h0);
		issue(CMD_READ, 32'd1, SZ_DWORD, 1'b1, 1'b1, 64'h0);
		issue(CMD_WRITE, 32'd65528, SZ_DWORD, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		issue(CMD_READ, 32'd65528, SZ_DWORD, 1'b1, 1'b0, 64'h0);
		issue(CMD_READ, 32'd65529, SZ_DWORD, 1'b0, 1'b0, 64'h0);
		issue(CMD_WRITE, 32'd65535, SZ_BYTE, 1'b0, 1'b0, 64'h0000_0000_0000_0080);
		issue(CMD_READ, 32'd65535, SZ_BYTE, 1'b1, 1'b0, 64'h0);
		issue(CMD_WRITE, 32'd65535, SZ_HALF, 1'b0, 1'b0, 64'h0000_0000_0000_1234);
		issue(CMD_READ, 32'd65534, SZ_HALF, 1'b0, 1'b1, 64'h0);
		issue(CMD_READ, 32'hFFFF_FFFF, SZ_DWORD, 1'b0, 1'b0, 64'h0);
		issue(CMD_WRITE, 32'hFFFF_FFF8, SZ_DWORD, 1'b0, 1'b0, 64'h0123_4567_89AB_CDEF);
		issue(CMD_READ, 32'h0001_0000, SZ_BYTE, 1'b0, 1'b0, 64'h0);
		issue(CMD_READ, 32'd100, SZ_WORD, 1'b1, 1'b1, 64'h0);
		repeat (580) issue_random();

		run_phase(17'd1, 100);
		run_phase(17'd0, 60);
		run_phase(17'h1_FFFF, 350);
		run_phase(17'd8, 150);
		run_phase(17'($urandom_range(9, 65535)), 400);
		run_phase(17'd65535, 300);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/bam_pkg.sv
design/bam_lane_ram.sv
design/byte_addressed_data_memory.sv
sim/mem_access_checker.sv
sim/tb_top.sv
